// ----- rtl/ppr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ppr_pkg;

    // Geometry
    localparam int SLOTS   = 3;
    localparam int MAX_LEN = 64;
    localparam int DEPTH   = SLOTS * MAX_LEN;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int SIDX_W  = $clog2(SLOTS);

    // Field widths
    localparam int ACTION_W = 2;
    localparam int SLOT_W   = 2;
    localparam int POS_W    = 6;
    localparam int DATA_W   = 16;
    localparam int FRAME_W  = 32;
    localparam int PERIOD_W = 16;
    localparam int LEN_W    = 7;
    localparam int CNT_W    = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATE_FORWARD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_SLOT0   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_SLOT1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_SLOT2   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_SLOT0   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_SLOT1   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_SLOT2   = 3'd7;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK     = 2'd0,
        ACT_WR_VALUE = 2'd1,
        ACT_WR_ORDER = 2'd2,
        ACT_RD_VALUE = 2'd3
    } action_t;

    // Controller -> datapath
    typedef struct packed {
        logic load_in;
        logic wr_value;
        logic wr_order;
        logic rd_value;
        logic cap_rdata;
        logic slot_clr;
        logic slot_inc;
        logic mod_start;
        logic head_ord;
        logic head_val;
        logic rot_rd;
        logic carry_cap;
        logic rot_wr;
        logic mask_set;
        logic out_load;
    } ppr_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        action_t action;
        logic    slot_active;
        logic    slot_last;
        logic    mod_busy;
        logic    rem_zero;
        logic    rem_last;
    } ppr_status_t;

endpackage

`default_nettype wire

// ----- rtl/ppr_mod.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Restoring remainder, one dividend bit per cycle.
module ppr_mod (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [ppr_pkg::FRAME_W-1:0]   dividend,
    input  wire logic [ppr_pkg::PERIOD_W-1:0]  divisor,
    output logic                               busy,
    output logic                               rem_zero
);

    localparam int CYC_W = $clog2(ppr_pkg::FRAME_W + 1);

    logic                            busy_reg;
    logic [CYC_W-1:0]                cyc_reg;
    logic [ppr_pkg::FRAME_W-1:0]     dvd_reg;
    logic [ppr_pkg::PERIOD_W-1:0]    rem_reg;
    logic [ppr_pkg::PERIOD_W:0]      trial;
    logic [ppr_pkg::PERIOD_W-1:0]    rem_next;

    always_comb begin
        trial = {rem_reg, dvd_reg[ppr_pkg::FRAME_W-1]};
        if (trial >= {1'b0, divisor}) begin
            rem_next = ppr_pkg::PERIOD_W'(trial - {1'b0, divisor});
        end else begin
            rem_next = trial[ppr_pkg::PERIOD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cyc_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cyc_reg  <= CYC_W'(ppr_pkg::FRAME_W);
        end else if (busy_reg) begin
            cyc_reg <= cyc_reg - CYC_W'(1);
            if (cyc_reg == CYC_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[ppr_pkg::FRAME_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign rem_zero = (rem_reg == '0);

endmodule

`default_nettype wire

// ----- rtl/ppr_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ppr_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    input  wire ppr_pkg::ppr_status_t st,
    output ppr_pkg::ppr_cmd_t         cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RD_WAIT,
        ST_SLOT_CHK,
        ST_MOD_RUN,
        ST_HEAD_ORD,
        ST_HEAD_VAL,
        ST_ROT_FIRST,
        ST_ROT_RD,
        ST_ROT_WR,
        ST_NEXT_SLOT,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (st.action)
                    ppr_pkg::ACT_TICK: begin
                        cmd.slot_clr = 1'b1;
                        state_next   = ST_SLOT_CHK;
                    end
                    ppr_pkg::ACT_WR_VALUE: begin
                        cmd.wr_value = 1'b1;
                        state_next   = ST_FINISH;
                    end
                    ppr_pkg::ACT_WR_ORDER: begin
                        cmd.wr_order = 1'b1;
                        state_next   = ST_FINISH;
                    end
                    ppr_pkg::ACT_RD_VALUE: begin
                        cmd.rd_value = 1'b1;
                        state_next   = ST_RD_WAIT;
                    end
                    default: begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_RD_WAIT: begin
                cmd.cap_rdata = 1'b1;
                state_next    = ST_FINISH;
            end
            ST_SLOT_CHK: begin
                if (st.slot_active) begin
                    cmd.mod_start = 1'b1;
                    state_next    = ST_MOD_RUN;
                end else begin
                    state_next = ST_NEXT_SLOT;
                end
            end
            ST_MOD_RUN: begin
                if (!st.mod_busy) begin
                    state_next = st.rem_zero ? ST_HEAD_ORD : ST_NEXT_SLOT;
                end
            end
            ST_HEAD_ORD: begin
                cmd.head_ord = 1'b1;
                state_next   = ST_HEAD_VAL;
            end
            ST_HEAD_VAL: begin
                cmd.head_val = 1'b1;
                state_next   = ST_ROT_FIRST;
            end
            ST_ROT_FIRST: begin
                cmd.rot_rd    = 1'b1;
                cmd.carry_cap = 1'b1;
                state_next    = ST_ROT_WR;
            end
            ST_ROT_RD: begin
                cmd.rot_rd = 1'b1;
                state_next = ST_ROT_WR;
            end
            ST_ROT_WR: begin
                cmd.rot_wr = 1'b1;
                if (st.rem_last) begin
                    cmd.mask_set = 1'b1;
                    state_next   = ST_NEXT_SLOT;
                end else begin
                    state_next = ST_ROT_RD;
                end
            end
            ST_NEXT_SLOT: begin
                if (st.slot_last) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.slot_inc = 1'b1;
                    state_next   = ST_SLOT_CHK;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ----- rtl/ppr_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ppr_dp (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [ppr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ppr_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic [ppr_pkg::ACTION_W-1:0]     s_action,
    input  wire logic [ppr_pkg::SLOT_W-1:0]       s_slot,
    input  wire logic [ppr_pkg::POS_W-1:0]        s_position,
    input  wire logic [ppr_pkg::DATA_W-1:0]       s_data,
    input  wire logic [ppr_pkg::FRAME_W-1:0]      s_frame_number,
    output logic      [ppr_pkg::DATA_W-1:0]       m_read_data,
    output logic      [ppr_pkg::SLOTS-1:0]        m_rotated_mask,
    input  wire ppr_pkg::ppr_cmd_t                cmd,
    output ppr_pkg::ppr_status_t                  st
);

    localparam int AW = ppr_pkg::ADDR_W;
    localparam int IW = ppr_pkg::IDX_W;
    localparam int LW = ppr_pkg::LEN_W;
    localparam int DW = ppr_pkg::DATA_W;
    localparam int CNT_EXT = (ppr_pkg::SIDX_W > ppr_pkg::CNT_W) ? ppr_pkg::SIDX_W
                                                                : ppr_pkg::CNT_W;

    // Configuration
    logic [ppr_pkg::CNT_W-1:0]    slot_count_reg;
    logic                         rotate_fwd_reg;
    logic [ppr_pkg::PERIOD_W-1:0] period_reg [ppr_pkg::SLOTS];
    logic [LW-1:0]                length_reg [ppr_pkg::SLOTS];

    // Latched transaction
    ppr_pkg::action_t             in_action_reg;
    logic [ppr_pkg::SLOT_W-1:0]   in_slot_reg;
    logic [ppr_pkg::POS_W-1:0]    in_pos_reg;
    logic [DW-1:0]                in_data_reg;
    logic [ppr_pkg::FRAME_W-1:0]  in_frame_reg;

    // Walk state
    logic [ppr_pkg::SIDX_W-1:0]   slot_cnt_reg;
    logic [IW-1:0]                pos_reg;
    logic [LW-1:0]                remain_reg;
    logic [IW-1:0]                idx_reg;
    logic [DW-1:0]                carry_reg;
    logic [DW-1:0]                rdata_reg;
    logic [ppr_pkg::SLOTS-1:0]    mask_reg;
    logic [DW-1:0]                m_read_data_reg;
    logic [ppr_pkg::SLOTS-1:0]    m_rotated_mask_reg;

    // Stores
    logic [DW-1:0]                val_mem [0:ppr_pkg::DEPTH-1];
    logic [IW-1:0]                ord_mem [0:ppr_pkg::DEPTH-1];
    logic [DW-1:0]                val_q_reg;
    logic [IW-1:0]                ord_q_reg;

    logic [ppr_pkg::PERIOD_W-1:0] period_sel;
    logic [LW-1:0]                len_sel;
    logic [LW-1:0]                len_sat;
    logic [LW-1:0]                len_dec;
    logic [IW-1:0]                len_m1;
    logic [IW-1:0]                head_pos;
    logic [IW-1:0]                start_pos;
    logic [IW-1:0]                pos_adv;
    logic                         addr_ok;
    logic [AW-1:0]                in_addr;
    logic [AW-1:0]                slot_base;
    logic                         val_rd_en;
    logic [AW-1:0]                val_rd_addr;
    logic                         val_wr_en;
    logic [AW-1:0]                val_wr_addr;
    logic [DW-1:0]                val_wr_data;
    logic                         ord_rd_en;
    logic [AW-1:0]                ord_rd_addr;
    logic                         ord_wr_en;
    logic                         mod_busy;
    logic                         mod_rem_zero;

    always_comb begin
        period_sel = period_reg[slot_cnt_reg];
        len_sel    = length_reg[slot_cnt_reg];
        len_sat    = (len_sel > LW'(ppr_pkg::MAX_LEN)) ? LW'(ppr_pkg::MAX_LEN) : len_sel;
        len_dec    = len_sat - LW'(1);
        len_m1     = len_dec[IW-1:0];
        head_pos   = rotate_fwd_reg ? len_m1 : '0;
        start_pos  = rotate_fwd_reg ? '0 : len_m1;
        pos_adv    = rotate_fwd_reg ? pos_reg + IW'(1) : pos_reg - IW'(1);
        addr_ok    = (int'(in_slot_reg) < ppr_pkg::SLOTS) &&
                     (int'(in_pos_reg) < ppr_pkg::MAX_LEN);
        in_addr    = AW'(in_slot_reg) * AW'(ppr_pkg::MAX_LEN) + AW'(in_pos_reg);
        slot_base  = AW'(slot_cnt_reg) * AW'(ppr_pkg::MAX_LEN);

        val_rd_en   = cmd.rd_value || cmd.head_val || cmd.rot_rd;
        val_rd_addr = cmd.rd_value ? in_addr : slot_base + AW'(ord_q_reg);
        val_wr_en   = (cmd.wr_value && addr_ok) || cmd.rot_wr;
        val_wr_addr = cmd.rot_wr ? slot_base + AW'(idx_reg) : in_addr;
        val_wr_data = cmd.rot_wr ? carry_reg : in_data_reg;

        ord_rd_en = cmd.head_ord || cmd.head_val || cmd.rot_rd;
        if (cmd.head_ord) begin
            ord_rd_addr = slot_base + AW'(head_pos);
        end else if (cmd.head_val) begin
            ord_rd_addr = slot_base + AW'(pos_reg);
        end else begin
            ord_rd_addr = slot_base + AW'(pos_adv);
        end
        ord_wr_en = cmd.wr_order && addr_ok;
    end

    always_ff @(posedge aclk) begin
        if (val_wr_en) begin
            val_mem[val_wr_addr] <= val_wr_data;
        end
        if (val_rd_en) begin
            val_q_reg <= val_mem[val_rd_addr];
        end
    end

    // Indices wrap to the list range on write.
    always_ff @(posedge aclk) begin
        if (ord_wr_en) begin
            ord_mem[in_addr] <= in_data_reg[IW-1:0];
        end
        if (ord_rd_en) begin
            ord_q_reg <= ord_mem[ord_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_count_reg <= '0;
            rotate_fwd_reg <= 1'b0;
            for (int i = 0; i < ppr_pkg::SLOTS; i++) begin
                period_reg[i] <= '0;
                length_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ppr_pkg::CFG_SLOT_COUNT:     slot_count_reg <= cfg_data[ppr_pkg::CNT_W-1:0];
                ppr_pkg::CFG_ROTATE_FORWARD: rotate_fwd_reg <= cfg_data[0];
                ppr_pkg::CFG_PERIOD_SLOT0:   period_reg[0]  <= cfg_data;
                ppr_pkg::CFG_PERIOD_SLOT1:   period_reg[1]  <= cfg_data;
                ppr_pkg::CFG_PERIOD_SLOT2:   period_reg[2]  <= cfg_data;
                ppr_pkg::CFG_LENGTH_SLOT0:   length_reg[0]  <= cfg_data[LW-1:0];
                ppr_pkg::CFG_LENGTH_SLOT1:   length_reg[1]  <= cfg_data[LW-1:0];
                ppr_pkg::CFG_LENGTH_SLOT2:   length_reg[2]  <= cfg_data[LW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_action_reg <= ppr_pkg::ACT_TICK;
            slot_cnt_reg  <= '0;
            pos_reg       <= '0;
            remain_reg    <= '0;
        end else begin
            if (cmd.load_in) begin
                in_action_reg <= ppr_pkg::action_t'(s_action);
            end
            if (cmd.slot_clr) begin
                slot_cnt_reg <= '0;
            end else if (cmd.slot_inc) begin
                slot_cnt_reg <= slot_cnt_reg + ppr_pkg::SIDX_W'(1);
            end
            if (cmd.head_ord) begin
                pos_reg    <= start_pos;
                remain_reg <= len_sat;
            end else if (cmd.rot_rd) begin
                pos_reg <= pos_adv;
            end else if (cmd.rot_wr) begin
                remain_reg <= remain_reg - LW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_slot_reg  <= s_slot;
            in_pos_reg   <= s_position;
            in_data_reg  <= s_data;
            in_frame_reg <= s_frame_number;
            rdata_reg    <= '0;
            mask_reg     <= '0;
        end else begin
            if (cmd.cap_rdata) begin
                rdata_reg <= addr_ok ? val_q_reg : '0;
            end
            if (cmd.mask_set) begin
                mask_reg[slot_cnt_reg] <= 1'b1;
            end
        end
        if (cmd.rot_rd) begin
            idx_reg <= ord_q_reg;
        end
        // Carry takes the head word first, then each displaced word in turn.
        if (cmd.carry_cap || cmd.rot_wr) begin
            carry_reg <= val_q_reg;
        end
        if (cmd.out_load) begin
            m_read_data_reg    <= rdata_reg;
            m_rotated_mask_reg <= mask_reg;
        end
    end

    ppr_mod u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.mod_start),
        .dividend (in_frame_reg),
        .divisor  (period_sel),
        .busy     (mod_busy),
        .rem_zero (mod_rem_zero)
    );

    always_comb begin
        st.action      = in_action_reg;
        st.slot_active = (CNT_EXT'(slot_cnt_reg) < CNT_EXT'(slot_count_reg)) &&
                         (period_sel != '0) && (len_sel != '0);
        st.slot_last   = (slot_cnt_reg == ppr_pkg::SIDX_W'(ppr_pkg::SLOTS - 1));
        st.mod_busy    = mod_busy;
        st.rem_zero    = mod_rem_zero;
        st.rem_last    = (remain_reg == LW'(1));
    end

    assign m_read_data    = m_read_data_reg;
    assign m_rotated_mask = m_rotated_mask_reg;

endmodule

`default_nettype wire

// ----- rtl/periodic_permuted_rotation_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// A write or read goes through decode to finish; a tick visits each slot in turn: an inactive slot is
// skipped, else the remainder unit runs, and the list rotates only if the period divides the frame.
// One transaction at a time: s_ready is high only in idle, and finish waits on m_ready if needed.
// Cost of a tick is set by the remainder wait and by a store read and write per list entry.
// Reset (aresetn, synchronous, active low) clears config and control; stores stay unset.

module periodic_permuted_rotation_top (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,

    // Configuration write port
    input  wire logic                             cfg_wr_en,
    input  wire logic [ppr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ppr_pkg::CFG_DATA_W-1:0]   cfg_data,

    // Request channel
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [ppr_pkg::ACTION_W-1:0]     s_action,
    input  wire logic [ppr_pkg::SLOT_W-1:0]       s_slot,
    input  wire logic [ppr_pkg::POS_W-1:0]        s_position,
    input  wire logic [ppr_pkg::DATA_W-1:0]       s_data,
    input  wire logic [ppr_pkg::FRAME_W-1:0]      s_frame_number,

    // Result channel
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic      [ppr_pkg::DATA_W-1:0]       m_read_data,
    output logic      [ppr_pkg::SLOTS-1:0]        m_rotated_mask
);

    // Controller sequences each transaction; datapath owns the stores,
    // the config registers, the remainder unit and the output register.
    ppr_pkg::ppr_cmd_t    cmd;
    ppr_pkg::ppr_status_t st;

    // The controller accepts a new transaction in idle even while the
    // previous result still sits in the output register; it only waits
    // at the end if that register has not yet been taken.
    ppr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .st      (st),
        .cmd     (cmd)
    );

    // Rotation walks the list as a carry chain: the head word is loaded
    // into the carry, then each listed entry is read and rewritten with
    // the carry in turn, so repeated indices behave as a swap sequence.
    ppr_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_action       (s_action),
        .s_slot         (s_slot),
        .s_position     (s_position),
        .s_data         (s_data),
        .s_frame_number (s_frame_number),
        .m_read_data    (m_read_data),
        .m_rotated_mask (m_rotated_mask),
        .cmd            (cmd),
        .st             (st)
    );

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

// Palette cycling block: every request transaction gives exactly one reply transaction.
// A software copy of the stores and registers predicts each reply when its request is
// accepted. Ticks are only issued once every list entry and store word they would
// touch has been written, so the missing writes are sent first.
module testbench;
    import ppr_pkg::*;

    localparam int QUIET_LIMIT = 6000;   // cycles with no transaction on either side

    typedef struct packed {
        action_t               action;
        logic [SLOT_W-1:0]     slot;
        logic [POS_W-1:0]      pos;
        logic [DATA_W-1:0]     data;
        logic [FRAME_W-1:0]    frame;
    } request_t;

    typedef struct packed {
        logic [DATA_W-1:0]     read_data;
        logic [SLOTS-1:0]      mask;
    } reply_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_wr_en;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    s_valid;
    logic                    s_ready;
    logic [ACTION_W-1:0]     s_action;
    logic [SLOT_W-1:0]       s_slot;
    logic [POS_W-1:0]        s_position;
    logic [DATA_W-1:0]       s_data;
    logic [FRAME_W-1:0]      s_frame_number;
    logic                    m_valid;
    logic                    m_ready;
    logic [DATA_W-1:0]       m_read_data;
    logic [SLOTS-1:0]        m_rotated_mask;

    periodic_permuted_rotation_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_slot         (s_slot),
        .s_position     (s_position),
        .s_data         (s_data),
        .s_frame_number (s_frame_number),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_read_data    (m_read_data),
        .m_rotated_mask (m_rotated_mask)
    );

    // Shadow copy of the block: registers, stores and which entries hold a written value
    logic [CNT_W-1:0]        sh_count;
    logic                    sh_forward;
    logic [PERIOD_W-1:0]     sh_period [SLOTS];
    logic [LEN_W-1:0]        sh_length [SLOTS];
    logic [DATA_W-1:0]       pal_value [SLOTS][MAX_LEN];
    logic [IDX_W-1:0]        pal_order [SLOTS][MAX_LEN];
    bit                      value_set [SLOTS][MAX_LEN];
    bit                      order_set [SLOTS][MAX_LEN];

    reply_t                  due_replies[$];
    int                      mismatches;
    int                      sent_items;
    int                      quiet_cycles;
    int                      stall_left;
    bit                      idle_on;

    // ---------------------------------------------------------------- prediction

    // Lengths above the list size saturate
    function automatic int eff_len(int s);
        return (sh_length[s] > MAX_LEN) ? MAX_LEN : int'(sh_length[s]);
    endfunction

    function automatic bit slot_turns(int s, logic [FRAME_W-1:0] frame);
        return s < sh_count && sh_period[s] != 0 && eff_len(s) != 0 &&
               (frame % {16'd0, sh_period[s]}) == 0;
    endfunction

    // One carried word swapped through each listed entry in turn, so repeated
    // indices behave as a chain rather than a true permutation
    function automatic void rotate_list(int s);
        int              n;
        int              k;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] carry;
        logic [DATA_W-1:0] old;
        n = eff_len(s);
        if (sh_forward) begin
            carry = pal_value[s][pal_order[s][n-1]];
            for (k = 0; k < n; k++) begin
                idx = pal_order[s][k];
                old = pal_value[s][idx];
                pal_value[s][idx] = carry;
                carry = old;
            end
        end else begin
            carry = pal_value[s][pal_order[s][0]];
            for (k = n - 1; k >= 0; k--) begin
                idx = pal_order[s][k];
                old = pal_value[s][idx];
                pal_value[s][idx] = carry;
                carry = old;
            end
        end
    endfunction

    function automatic reply_t apply_request(request_t rq);
        reply_t rep;
        int     s;
        rep = '0;
        case (rq.action)
            ACT_TICK: begin
                for (s = 0; s < SLOTS; s++) begin
                    if (slot_turns(s, rq.frame)) begin
                        rotate_list(s);
                        rep.mask[s] = 1'b1;
                    end
                end
            end
            ACT_WR_VALUE: begin
                if (rq.slot < SLOTS) begin
                    pal_value[rq.slot][rq.pos] = rq.data;
                    value_set[rq.slot][rq.pos] = 1'b1;
                end
            end
            ACT_WR_ORDER: begin
                if (rq.slot < SLOTS) begin
                    pal_order[rq.slot][rq.pos] = rq.data[IDX_W-1:0];
                    order_set[rq.slot][rq.pos] = 1'b1;
                end
            end
            default: begin
                if (rq.slot < SLOTS)
                    rep.read_data = pal_value[rq.slot][rq.pos];
            end
        endcase
        return rep;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic request_t mk(action_t a, int sl, int p, logic [DATA_W-1:0] d,
                                    logic [FRAME_W-1:0] f);
        request_t r;
        r.action = a;
        r.slot   = sl[SLOT_W-1:0];
        r.pos    = p[POS_W-1:0];
        r.data   = d;
        r.frame  = f;
        return r;
    endfunction

    // Order words: junk in the upper bits (wraps), and often a narrow index range so
    // that lists pick up repeated entries
    function automatic logic [DATA_W-1:0] order_word();
        logic [IDX_W-1:0] i;
        i = $urandom_range(0, 1) ? IDX_W'($urandom_range(0, 7)) : IDX_W'($urandom);
        return {10'($urandom), i};
    endfunction

    // First write still missing before a tick at this frame may run
    function automatic bit find_gap(logic [FRAME_W-1:0] frame, output request_t rq);
        int s;
        int k;
        rq = '0;
        for (s = 0; s < SLOTS; s++) begin
            if (slot_turns(s, frame)) begin
                for (k = 0; k < eff_len(s); k++) begin
                    if (!order_set[s][k]) begin
                        rq = mk(ACT_WR_ORDER, s, k, order_word(), $urandom);
                        return 1'b1;
                    end
                    if (!value_set[s][pal_order[s][k]]) begin
                        rq = mk(ACT_WR_VALUE, s, int'(pal_order[s][k]), DATA_W'($urandom),
                                $urandom);
                        return 1'b1;
                    end
                end
            end
        end
        return 1'b0;
    endfunction

    // Frames: zero, all ones, random, small, and multiples of a slot's period
    function automatic logic [FRAME_W-1:0] pick_frame();
        int                  r;
        logic [PERIOD_W-1:0] per;
        r = $urandom_range(0, 9);
        per = sh_period[$urandom_range(0, SLOTS - 1)];
        case (r)
            0:       return '0;
            1:       return '1;
            2, 3:    return $urandom;
            4, 5:    return $urandom_range(0, 255);
            default: return (per == 0) ? $urandom : 32'(per) * 32'($urandom_range(0, 65535));
        endcase
    endfunction

    // Drive one request at the falling edge and hold it until the transaction completes
    task automatic send_request(input request_t rq);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_action       <= rq.action;
        s_slot         <= rq.slot;
        s_position     <= rq.pos;
        s_data         <= rq.data;
        s_frame_number <= rq.frame;
        do @(posedge aclk); while (!s_ready);
        due_replies.push_back(apply_request(rq));
        sent_items++;
    endtask

    // Sender holds off until every outstanding reply has come back
    task automatic drain_replies();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (due_replies.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        case (idx)
            CFG_SLOT_COUNT:     sh_count     = val[CNT_W-1:0];
            CFG_ROTATE_FORWARD: sh_forward   = val[0];
            CFG_PERIOD_SLOT0:   sh_period[0] = val;
            CFG_PERIOD_SLOT1:   sh_period[1] = val;
            CFG_PERIOD_SLOT2:   sh_period[2] = val;
            CFG_LENGTH_SLOT0:   sh_length[0] = val[LEN_W-1:0];
            CFG_LENGTH_SLOT1:   sh_length[1] = val[LEN_W-1:0];
            CFG_LENGTH_SLOT2:   sh_length[2] = val[LEN_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Full register set, written only once the block is idle; unused upper bits carry junk
    task automatic apply_settings(input logic [CNT_W-1:0] cnt, input logic fwd,
                                  input logic [PERIOD_W-1:0] p0, p1, p2,
                                  input logic [LEN_W-1:0] l0, l1, l2);
        drain_replies();
        write_reg(CFG_SLOT_COUNT,     {14'($urandom), cnt});
        write_reg(CFG_ROTATE_FORWARD, {15'($urandom), fwd});
        write_reg(CFG_PERIOD_SLOT0,   p0);
        write_reg(CFG_PERIOD_SLOT1,   p1);
        write_reg(CFG_PERIOD_SLOT2,   p2);
        write_reg(CFG_LENGTH_SLOT0,   {9'($urandom), l0});
        write_reg(CFG_LENGTH_SLOT1,   {9'($urandom), l1});
        write_reg(CFG_LENGTH_SLOT2,   {9'($urandom), l2});
    endtask

    // Mostly well-formed traffic: ticks preceded by whatever writes they still need,
    // reads only of written words or of the unused slot, plus writes to the unused slot as noise
    task automatic run_random_phase(input int count);
        int       stop_at;
        int       r;
        int       sl;
        int       p;
        request_t rq;
        logic [FRAME_W-1:0] frame;
        stop_at = sent_items + count;
        while (sent_items < stop_at) begin
            r  = $urandom_range(0, 99);
            sl = ($urandom_range(0, 7) == 0) ? 3 : $urandom_range(0, SLOTS - 1);
            p  = $urandom_range(0, MAX_LEN - 1);
            if (r < 40) begin
                frame = pick_frame();
                while (find_gap(frame, rq)) send_request(rq);
                send_request(mk(ACT_TICK, $urandom_range(0, 3), p, DATA_W'($urandom), frame));
            end else if (r < 65) begin
                send_request(mk(ACT_WR_VALUE, sl, p, DATA_W'($urandom), $urandom));
            end else if (r < 80) begin
                send_request(mk(ACT_WR_ORDER, sl, p, order_word(), $urandom));
            end else begin
                if (sl < SLOTS && !value_set[sl][p])
                    send_request(mk(ACT_WR_VALUE, sl, p, DATA_W'($urandom), $urandom));
                send_request(mk(ACT_RD_VALUE, sl, p, DATA_W'($urandom), $urandom));
            end
        end
    endtask

    // ---------------------------------------------------------------- tests

    // Reset state: rotation off, unused slot ignored on write and reads as zero
    task automatic test_idle_defaults();
        send_request(mk(ACT_TICK, 0, 0, 16'h0000, 32'd0));
        send_request(mk(ACT_WR_VALUE, 1, 0, 16'h0000, 32'hFFFF_FFFF));
        send_request(mk(ACT_RD_VALUE, 1, 0, 16'hFFFF, 32'd0));
        send_request(mk(ACT_WR_VALUE, 3, 63, 16'hFFFF, 32'd0));
        send_request(mk(ACT_WR_ORDER, 3, 63, 16'hFFFF, 32'd0));
        send_request(mk(ACT_RD_VALUE, 3, 63, 16'h0000, 32'd0));
    endtask

    // Forward rotation through a list with a repeated and a wrapped index, a period
    // of zero, a one-entry list, frame extremes
    task automatic test_rotation_basics();
        apply_settings(2'd3, 1'b1, 16'd1, 16'd0, 16'd3, 7'd3, 7'd1, 7'd1);
        send_request(mk(ACT_WR_ORDER, 0, 0, 16'd5, 32'd0));
        send_request(mk(ACT_WR_ORDER, 0, 1, 16'd70, 32'd0));      // wraps to 6
        send_request(mk(ACT_WR_ORDER, 0, 2, 16'hFFC5, 32'd0));    // wraps to 5 again
        send_request(mk(ACT_WR_VALUE, 0, 5, 16'hAAAA, 32'd0));
        send_request(mk(ACT_WR_VALUE, 0, 6, 16'h5555, 32'd0));
        send_request(mk(ACT_WR_ORDER, 2, 0, 16'hFFFF, 32'd0));
        send_request(mk(ACT_WR_VALUE, 2, 63, 16'hFFFF, 32'd0));
        send_request(mk(ACT_TICK, 3, 63, 16'hFFFF, 32'd0));
        send_request(mk(ACT_TICK, 0, 0, 16'h0000, 32'hFFFF_FFFF));
        send_request(mk(ACT_TICK, 0, 0, 16'h0000, 32'd7));
        send_request(mk(ACT_RD_VALUE, 0, 5, 16'd0, 32'd0));
        send_request(mk(ACT_RD_VALUE, 0, 6, 16'd0, 32'd0));
        send_request(mk(ACT_RD_VALUE, 2, 63, 16'd0, 32'd0));
    endtask

    // Backward rotation with one active slot; slot 2 would divide but is inactive
    task automatic test_backward_rotation();
        apply_settings(2'd1, 1'b0, 16'd1, 16'd0, 16'd3, 7'd3, 7'd1, 7'd1);
        send_request(mk(ACT_TICK, 0, 0, 16'd0, 32'd3));
        send_request(mk(ACT_RD_VALUE, 0, 5, 16'd0, 32'd0));
        send_request(mk(ACT_RD_VALUE, 0, 6, 16'd0, 32'd0));
    endtask

    // Random traffic over several register settings, extremes among them
    task automatic test_random_mix();
        apply_settings(2'd3, 1'b1, PERIOD_W'($urandom_range(1, 6)),
                       PERIOD_W'($urandom_range(1, 6)), PERIOD_W'($urandom_range(1, 6)),
                       LEN_W'($urandom_range(1, 10)), LEN_W'($urandom_range(1, 10)),
                       LEN_W'($urandom_range(1, 10)));
        run_random_phase(150);
        // full list, saturated length, longest period
        apply_settings(2'd3, 1'b0, 16'd1, 16'hFFFF, 16'd0, 7'd64, 7'd127, 7'd1);
        run_random_phase(200);
        apply_settings(2'd2, 1'b1, PERIOD_W'($urandom), PERIOD_W'($urandom),
                       PERIOD_W'($urandom), 7'd0, LEN_W'($urandom_range(2, 20)), 7'd9);
        run_random_phase(120);
        apply_settings(2'd1, 1'b0, 16'd2, 16'd1, 16'd1, 7'd5, 7'd2, 7'd2);
        run_random_phase(80);
        apply_settings(2'd0, 1'b1, 16'd1, 16'd1, 16'd1, 7'd3, 7'd3, 7'd3);
        run_random_phase(40);
    endtask

    // Last stretch with neither side stalling
    task automatic test_steady_flow();
        apply_settings(2'd3, 1'($urandom), PERIOD_W'($urandom_range(1, 4)),
                       PERIOD_W'($urandom_range(1, 4)), PERIOD_W'($urandom_range(1, 4)),
                       LEN_W'($urandom_range(1, 16)), LEN_W'($urandom_range(1, 16)),
                       LEN_W'($urandom_range(1, 16)));
        idle_on = 1'b0;
        run_random_phase(150);
    endtask

    // ---------------------------------------------------------------- clock, reset, run

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_action       = '0;
        s_slot         = '0;
        s_position     = '0;
        s_data         = '0;
        s_frame_number = '0;
        sh_count       = '0;
        sh_forward     = 1'b0;
        for (int s = 0; s < SLOTS; s++) begin
            sh_period[s] = '0;
            sh_length[s] = '0;
            for (int k = 0; k < MAX_LEN; k++) begin
                pal_value[s][k] = '0;
                pal_order[s][k] = '0;
                value_set[s][k] = 1'b0;
                order_set[s][k] = 1'b0;
            end
        end
        mismatches = 0;
        sent_items = 0;
        idle_on    = 1'b1;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_idle_defaults();
        test_rotation_basics();
        test_backward_rotation();
        test_random_mix();
        test_steady_flow();

        drain_replies();
        repeat (50) @(posedge aclk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Reply side back-pressure: random stall bursts while idle_on is set
    initial begin
        m_ready    = 1'b0;
        stall_left = 0;
    end

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 5) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Each reply transaction against the oldest prediction
    always @(posedge aclk) begin
        reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_replies.size() == 0) begin
                $error("reply with none outstanding: read_data %h rotated_mask %b",
                       m_read_data, m_rotated_mask);
                mismatches++;
            end else begin
                want = due_replies.pop_front();
                if (m_read_data !== want.read_data) begin
                    $error("read_data: expected %h, got %h", want.read_data, m_read_data);
                    mismatches++;
                end
                if (m_rotated_mask !== want.mask) begin
                    $error("rotated_mask: expected %b, got %b", want.mask, m_rotated_mask);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: too long without any transaction means the block has hung
    initial quiet_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
